/* hw/rtl/crce_pkg.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom curve evaluator package
// Shared command codes and the beat payload types of both channels.
// ----------------------------------------------------------------------------
package crce_pkg;

  localparam logic [1:0] ACT_NEW    = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_EVAL   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [16:0]        curve_param;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic               empty_error;
  } rsp_t;

endpackage

/* hw/rtl/crce_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/catmull_rom_curve_eval.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom curve evaluator
// Stores control points and evaluates the cubic Hermite curve through them
// with one shared multiplier and a bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------
//  command   | start / busy            | cmd_i    (crce_pkg::cmd_t)
//  result    | result_valid_o (strobe) | result_o (crce_pkg::rsp_t)
//
//  An append that stores the second point derives the virtual point in ST_MKV.
//  An evaluate beat with N >= 2 stored points runs a linear segment search
//  that reads one point per cycle, a divider that retires one quotient bit
//  per cycle and shared multiplier steps of issue, wait and take phases.
//  With zero or one point an evaluate answers from ST_ONE without a search.
//  The result strobe lasts one cycle and the receiver cannot stall it.
//  Reset clears the point count; the point memory is not cleared.
// ----------------------------------------------------------------------------
module catmull_rom_curve_eval #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  crce_pkg::cmd_t  cmd_i,
  output logic            result_valid_o,
  output crce_pkg::rsp_t  result_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = $clog2(MAX_POINTS + 2);
  localparam int XW = 36;
  localparam int NW = 37;
  localparam int PW = 70;
  localparam int OW = 35;
  localparam int EPS = ((1 << FRAC_BITS) + 500) / 1000;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

  localparam logic [3:0] STEP_XPOS = 4'd0;
  localparam logic [3:0] STEP_OM2  = 4'd1;
  localparam logic [3:0] STEP_H00  = 4'd2;
  localparam logic [3:0] STEP_H10  = 4'd3;
  localparam logic [3:0] STEP_UU   = 4'd4;
  localparam logic [3:0] STEP_H01  = 4'd5;
  localparam logic [3:0] STEP_H11  = 4'd6;
  localparam logic [3:0] STEP_ACC0 = 4'd7;
  localparam logic [3:0] STEP_ACC1 = 4'd8;
  localparam logic [3:0] STEP_ACC2 = 4'd9;
  localparam logic [3:0] STEP_ACC3 = 4'd10;

  localparam logic [1:0] PH_ISSUE = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_TAKE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MKV,
    ST_ONE,
    ST_RD1,
    ST_SPAN,
    ST_MUL,
    ST_SRCH,
    ST_FETCH,
    ST_PREP,
    ST_UDEC,
    ST_DIV,
    ST_FIN
  } state_e;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Control registers
  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d;
  logic               rv_q, rv_d;
  crce_pkg::rsp_t     res_q, res_d;
  logic [3:0]         hs_q, hs_d;
  logic [1:0]         ph_q, ph_d;
  logic [EW-1:0]      e_q, e_d;
  logic [2:0]         k_q, k_d;
  logic [3:0]         dcnt_q, dcnt_d;

  // Datapath registers
  crce_pkg::cmd_t     cmd_q, cmd_d;
  logic signed [31:0] x0_q, x0_d;
  logic signed [32:0] span_q, span_d;
  logic signed [XW-1:0] x_q, x_d;
  logic signed [31:0] x1_q, x1_d, x2_q, x2_d;
  logic signed [31:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic signed [33:0] m1_q, m1_d, m2_q, m2_d;
  logic signed [NW-1:0] num_q, num_d;
  logic signed [32:0] den_q, den_d;
  logic [31:0]        rem_q, rem_d;
  logic [15:0]        dlo_q, dlo_d, quo_q, quo_d;
  logic [16:0]        u_q, u_d;
  logic signed [OW-1:0] op_a_q, op_a_d, op_b_q, op_b_d;
  logic signed [PW-1:0] prod_q, acc_q, acc_d;
  logic [33:0]        om2_q, om2_d, uu_q, uu_d;
  logic signed [31:0] h00_q, h00_d, h10_q, h10_d, h01_q, h01_d, h11_q, h11_d;

  // Memory port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [63:0]        ram_wdata, ram_rdata;
  logic signed [31:0] ram_x, ram_y;

  crce_ram #(
    .WIDTH(64),
    .DEPTH(MAX_POINTS)
  ) u_knots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_x = ram_rdata[31:0];
  assign ram_y = ram_rdata[63:32];

  // Virtual point: first point minus one step, a zero step replaced by EPS.
  logic signed [32:0] dx_raw, dy_raw, dx_s, dy_s;
  logic signed [33:0] vx_raw, vy_raw;
  assign dx_raw = {cmd_q.point_x[31], cmd_q.point_x} - {ram_x[31], ram_x};
  assign dy_raw = {cmd_q.point_y[31], cmd_q.point_y} - {ram_y[31], ram_y};
  assign dx_s   = (dx_raw == '0) ? 33'(EPS) : dx_raw;
  assign dy_s   = (dy_raw == '0) ? 33'(EPS) : dy_raw;
  assign vx_raw = {{2{ram_x[31]}}, ram_x} - {dx_s[32], dx_s};
  assign vy_raw = {{2{ram_y[31]}}, ram_y} - {dy_s[32], dy_s};

  // Segment search
  logic [EW-1:0]        ext_w, e_clamp;
  logic signed [31:0]   ex_pt;
  logic signed [XW-1:0] ex_w;
  assign ext_w = EW'(cnt_q) + EW'(1);
  assign ex_pt = (e_q == '0) ? vx_q : ram_x;
  assign ex_w  = {{(XW-32){ex_pt[31]}}, ex_pt};

  always_comb begin
    e_clamp = (e_q >= ext_w) ? EW'(cnt_q) : e_q;
    if (e_clamp == '0) begin
      e_clamp = EW'(1);
    end
  end

  // Neighbor fetch: cycle k reads the knot behind extended point e-2+k.
  logic [EW+1:0]      f_sum;
  logic               f_virt;
  logic signed [31:0] f_x, f_y;
  assign f_sum  = (EW+2)'(e_q) + (EW+2)'(k_q);
  assign f_virt = (f_sum == (EW+2)'(3));
  assign f_x    = f_virt ? vx_q : ram_x;
  assign f_y    = f_virt ? vy_q : ram_y;

  // Tangents (doubled), local offset and segment width
  logic signed [33:0]   d21, m1_w, m2_w;
  logic signed [NW-1:0] num_w, den_ext;
  logic signed [32:0]   den_w;
  logic [47:0]          dval;
  assign d21   = {{2{p2_q[31]}}, p2_q} - {{2{p1_q[31]}}, p1_q};
  assign m1_w  = (e_q != EW'(1)) ? ({{2{p2_q[31]}}, p2_q} - {{2{p0_q[31]}}, p0_q})
                                 : (d21 <<< 1);
  assign m2_w  = (e_q < EW'(cnt_q)) ? ({{2{p3_q[31]}}, p3_q} - {{2{p1_q[31]}}, p1_q})
                                    : (d21 <<< 1);
  assign num_w = {x_q[XW-1], x_q} - {{(NW-32){x1_q[31]}}, x1_q};
  assign den_w = {x2_q[31], x2_q} - {x1_q[31], x1_q};
  assign den_ext = {{(NW-33){den_q[32]}}, den_q};
  assign dval  = {num_q[31:0], 16'b0} + {17'b0, den_q[31:1]};

  // Divider step
  logic [32:0] r2;
  logic        qbit;
  assign r2   = {rem_q, dlo_q[15]};
  assign qbit = (r2 >= {1'b0, den_q[31:0]});

  // Shared multiplier operands
  logic [16:0]          om_w;
  logic [17:0]          h00f, h01f;
  logic signed [17:0]   h11f;
  logic signed [OW-1:0] sel_a, sel_b;
  assign om_w = 17'd65536 - u_q;
  assign h00f = 18'd65536 + {u_q, 1'b0};
  assign h01f = 18'd196608 - {u_q, 1'b0};
  assign h11f = $signed({1'b0, u_q}) - 18'sd65536;

  always_comb begin
    case (hs_q)
      STEP_XPOS: begin
        sel_a = {18'b0, cmd_q.curve_param};
        sel_b = {{2{span_q[32]}}, span_q};
      end
      STEP_OM2: begin
        sel_a = {18'b0, om_w};
        sel_b = {18'b0, om_w};
      end
      STEP_H00: begin
        sel_a = {17'b0, h00f};
        sel_b = {1'b0, om2_q};
      end
      STEP_H10: begin
        sel_a = {18'b0, u_q};
        sel_b = {1'b0, om2_q};
      end
      STEP_UU: begin
        sel_a = {18'b0, u_q};
        sel_b = {18'b0, u_q};
      end
      STEP_H01: begin
        sel_a = {1'b0, uu_q};
        sel_b = {17'b0, h01f};
      end
      STEP_H11: begin
        sel_a = {1'b0, uu_q};
        sel_b = {{17{h11f[17]}}, h11f};
      end
      STEP_ACC0: begin
        sel_a = {{3{h00_q[31]}}, h00_q};
        sel_b = {{3{p1_q[31]}}, p1_q};
      end
      STEP_ACC1: begin
        sel_a = {{3{h01_q[31]}}, h01_q};
        sel_b = {{3{p2_q[31]}}, p2_q};
      end
      STEP_ACC2: begin
        sel_a = {{3{h10_q[31]}}, h10_q};
        sel_b = {m1_q[33], m1_q};
      end
      STEP_ACC3: begin
        sel_a = {{3{h11_q[31]}}, h11_q};
        sel_b = {m2_q[33], m2_q};
      end
      default: begin
        sel_a = '0;
        sel_b = '0;
      end
    endcase
  end

  // Rounded views of the product and of the final sum
  logic signed [PW-1:0] pr16, pr20, accr;
  logic signed [31:0]   fin_val;
  assign pr16 = (prod_q + PW'(32768)) >>> 16;
  assign pr20 = (prod_q + PW'(524288)) >>> 20;
  assign accr = (acc_q + PW'(268435456)) >>> 29;
  always_comb begin
    if (accr > PW'(2147483647)) begin
      fin_val = 32'sh7fffffff;
    end else if (accr < -(PW'(64'sd2147483648))) begin
      fin_val = 32'sh80000000;
    end else begin
      fin_val = accr[31:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    rv_d    = 1'b0;
    res_d   = res_q;
    hs_d    = hs_q;
    ph_d    = ph_q;
    e_d     = e_q;
    k_d     = k_q;
    dcnt_d  = dcnt_q;
    cmd_d   = cmd_q;
    x0_d    = x0_q;
    span_d  = span_q;
    x_d     = x_q;
    x1_d    = x1_q;
    x2_d    = x2_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    p3_d    = p3_q;
    m1_d    = m1_q;
    m2_d    = m2_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dlo_d   = dlo_q;
    quo_d   = quo_q;
    u_d     = u_q;
    op_a_d  = op_a_q;
    op_b_d  = op_b_q;
    acc_d   = acc_q;
    om2_d   = om2_q;
    uu_d    = uu_q;
    h00_d   = h00_q;
    h10_d   = h10_q;
    h01_d   = h01_q;
    h11_d   = h11_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {cmd_i.point_y, cmd_i.point_x};
    ram_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        // The first knot is read here so that it is ready next cycle.
        if (start) begin
          cmd_d = cmd_i;
          unique case (cmd_i.action)
            crce_pkg::ACT_NEW: begin
              ram_we = 1'b1;
              cnt_d  = CW'(1);
            end
            crce_pkg::ACT_APPEND: begin
              if (cnt_q < CNT_MAX) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AW-1:0];
                cnt_d     = cnt_q + CW'(1);
                if (cnt_q == CW'(1)) begin
                  state_d = ST_MKV;
                end
              end
            end
            crce_pkg::ACT_EVAL: begin
              state_d = (cnt_q < CW'(2)) ? ST_ONE : ST_RD1;
            end
            default: ;
          endcase
        end
      end
      ST_MKV: begin
        vx_d    = sat34(vx_raw);
        vy_d    = sat34(vy_raw);
        state_d = ST_IDLE;
      end
      ST_ONE: begin
        rv_d              = 1'b1;
        res_d.empty_error = (cnt_q == '0);
        res_d.curve_value = (cnt_q == '0) ? '0 : ram_y;
        state_d           = ST_IDLE;
      end
      ST_RD1: begin
        ram_raddr = AW'(cnt_q - CW'(1));
        x0_d      = ram_x;
        state_d   = ST_SPAN;
      end
      ST_SPAN: begin
        span_d  = {ram_x[31], ram_x} - {x0_q[31], x0_q};
        hs_d    = STEP_XPOS;
        ph_d    = PH_ISSUE;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        case (ph_q)
          PH_ISSUE: begin
            op_a_d = sel_a;
            op_b_d = sel_b;
            ph_d   = PH_WAIT;
          end
          PH_WAIT: begin
            ph_d = PH_TAKE;
          end
          default: begin
            ph_d = PH_ISSUE;
            hs_d = hs_q + 4'd1;
            case (hs_q)
              STEP_XPOS: begin
                x_d     = pr16[XW-1:0];
                e_d     = '0;
                state_d = ST_SRCH;
              end
              STEP_OM2:  om2_d = prod_q[33:0];
              STEP_H00:  h00_d = pr20[31:0];
              STEP_H10:  h10_d = pr20[31:0];
              STEP_UU:   uu_d  = prod_q[33:0];
              STEP_H01:  h01_d = pr20[31:0];
              STEP_H11:  h11_d = pr20[31:0];
              STEP_ACC0: acc_d = prod_q <<< 1;
              STEP_ACC1: acc_d = acc_q + (prod_q <<< 1);
              STEP_ACC2: acc_d = acc_q + prod_q;
              default: begin
                acc_d   = acc_q + prod_q;
                state_d = ST_FIN;
              end
            endcase
          end
        endcase
      end
      ST_SRCH: begin
        // Prefetch the point after the one compared in this cycle.
        ram_raddr = e_q[AW-1:0];
        if (e_q >= ext_w || ex_w >= x_q) begin
          e_d     = e_clamp;
          k_d     = '0;
          state_d = ST_FETCH;
        end else begin
          e_d = e_q + EW'(1);
        end
      end
      ST_FETCH: begin
        ram_raddr = AW'(f_sum - (EW+2)'(3));
        case (k_q)
          3'd1: p0_d = f_y;
          3'd2: begin
            x1_d = f_x;
            p1_d = f_y;
          end
          3'd3: begin
            x2_d = f_x;
            p2_d = f_y;
          end
          3'd4: p3_d = f_y;
          default: ;
        endcase
        if (k_q == 3'd4) begin
          state_d = ST_PREP;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_PREP: begin
        num_d   = num_w;
        den_d   = den_w;
        m1_d    = m1_w;
        m2_d    = m2_w;
        state_d = ST_UDEC;
      end
      ST_UDEC: begin
        hs_d = STEP_OM2;
        ph_d = PH_ISSUE;
        if (den_q <= 33'sd0 || num_q <= NW'(0)) begin
          u_d     = '0;
          state_d = ST_MUL;
        end else if (num_q >= den_ext) begin
          u_d     = 17'd65536;
          state_d = ST_MUL;
        end else if (dval[47:16] >= den_q[31:0]) begin
          // On a wide segment the rounded quotient can reach one whole unit.
          u_d     = 17'd65536;
          state_d = ST_MUL;
        end else begin
          rem_d   = dval[47:16];
          dlo_d   = dval[15:0];
          quo_d   = '0;
          dcnt_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = qbit ? 32'(r2 - {1'b0, den_q[31:0]}) : r2[31:0];
        quo_d  = {quo_q[14:0], qbit};
        dlo_d  = {dlo_q[14:0], 1'b0};
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd15) begin
          u_d     = {1'b0, quo_q[14:0], qbit};
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        rv_d              = 1'b1;
        res_d.curve_value = fin_val;
        res_d.empty_error = 1'b0;
        state_d           = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      rv_q    <= 1'b0;
      res_q   <= '0;
      hs_q    <= STEP_XPOS;
      ph_q    <= PH_ISSUE;
      e_q     <= '0;
      k_q     <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
      rv_q    <= rv_d;
      res_q   <= res_d;
      hs_q    <= hs_d;
      ph_q    <= ph_d;
      e_q     <= e_d;
      k_q     <= k_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    x0_q   <= x0_d;
    span_q <= span_d;
    x_q    <= x_d;
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    p3_q   <= p3_d;
    m1_q   <= m1_d;
    m2_q   <= m2_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    dlo_q  <= dlo_d;
    quo_q  <= quo_d;
    u_q    <= u_d;
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    prod_q <= PW'(op_a_q * op_b_q);
    acc_q  <= acc_d;
    om2_q  <= om2_d;
    uu_q   <= uu_d;
    h00_q  <= h00_d;
    h10_q  <= h10_d;
    h01_q  <= h01_d;
    h11_q  <= h11_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;

endmodule

/* hw/rtl/crce_checker.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom curve evaluator port checker
// Watches the top-level ports for command and result sequencing.
// ----------------------------------------------------------------------------
module crce_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input crce_pkg::cmd_t cmd_i,
  input logic           result_valid_o,
  input crce_pkg::rsp_t result_o
);

  // An evaluate beat always makes the block busy in the next cycle.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.action == crce_pkg::ACT_EVAL |=> busy)
    else $error("evaluate beat did not make the block busy");

  // New-curve, append and other non-evaluate beats never produce a result in the next cycle.
  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.action != crce_pkg::ACT_EVAL |=> !result_valid_o)
    else $error("result strobe after a non-evaluate beat");

  // Each result is a single-cycle strobe.
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  // The result is shown while the block is idle again.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // An empty-curve error carries a zero value.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.empty_error |-> result_o.curve_value == '0)
    else $error("empty-curve result with nonzero value");

endmodule

bind catmull_rom_curve_eval crce_checker u_crce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .cmd_i         (cmd_i),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom curve evaluator testbench
// Drives new-curve, append and evaluate commands with random gaps, predicts
// evaluate results (fixed-point Hermite for 2+ points) and checks each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int          MAXP     = 64;
  localparam int          WDOG_MAX = 20000;
  localparam logic [1:0]  ACT_NONE = 2'd3;
  localparam longint      T_ONE    = 65536;
  localparam longint      EPS_STEP = 66;
  localparam longint      S32_MAX  = 64'sd2147483647;
  localparam longint      S32_MIN  = -64'sd2147483648;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  crce_pkg::cmd_t cmd_i = '0;
  logic           result_valid_o;
  crce_pkg::rsp_t result_o;

  catmull_rom_curve_eval dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the point store.
  longint kx[MAXP];
  longint ky[MAXP];
  int     knots;
  longint vx, vy;

  crce_pkg::cmd_t pending_cmds[$];
  crce_pkg::rsp_t expected_values[$];
  int     mismatches = 0;
  int     sender_idle_pct = 0;
  bit     hold_off = 1'b0;
  bit     stim_done = 1'b0;
  int     quiet_cycles = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic void ext_point(int e, output longint x, output longint y);
    if (e == 0 || e > knots) begin
      x = vx;
      y = vy;
    end else begin
      x = kx[e-1];
      y = ky[e-1];
    end
  endfunction

  function automatic longint hermite_value(logic [16:0] traw);
    int     ext;
    int     e;
    longint t, span, x, ex, ey, x1, p1, x2, p2, p0, p3, m1, m2, u, num, den;
    longint om, h00, h10, h01, h11, sum;
    ext = knots + 1;
    t = longint'(traw);
    span = kx[knots-1] - kx[0];
    x = round_shr(t * span, 16);
    e = 0;
    forever begin
      ext_point(e, ex, ey);
      if (e >= ext || ex >= x) break;
      e++;
    end
    if (e >= ext) e = ext - 1;
    if (e == 0) e = 1;
    ext_point(e, x2, p2);
    ext_point(e - 1, x1, p1);
    if (e != 1) begin
      ext_point(e - 2, ex, p0);
      m1 = p2 - p0;
    end else begin
      m1 = 2 * (p2 - p1);
    end
    if (e + 1 < ext) begin
      ext_point(e + 1, ex, p3);
      m2 = p3 - p1;
    end else begin
      m2 = 2 * (p2 - p1);
    end
    num = x - x1;
    den = x2 - x1;
    if (den <= 0 || num <= 0) u = 0;
    else if (num >= den) u = T_ONE;
    else u = (num * T_ONE + den / 2) / den;
    om = T_ONE - u;
    h00 = round_shr((T_ONE + 2 * u) * om * om, 20);
    h10 = round_shr(u * om * om, 20);
    h01 = round_shr(u * u * (3 * T_ONE - 2 * u), 20);
    h11 = round_shr(u * u * (u - T_ONE), 20);
    sum = 2 * (h00 * p1 + h01 * p2) + h10 * m1 + h11 * m2;
    return sat32(round_shr(sum, 29));
  endfunction

  // Updates the shadow store for one accepted beat and queues any result.
  function automatic void predict_curve(crce_pkg::cmd_t c);
    crce_pkg::rsp_t r;
    longint dx, dy;
    case (c.action)
      crce_pkg::ACT_NEW: begin
        kx[0] = c.point_x;
        ky[0] = c.point_y;
        knots = 1;
      end
      crce_pkg::ACT_APPEND: begin
        if (knots < MAXP) begin
          kx[knots] = c.point_x;
          ky[knots] = c.point_y;
          knots++;
          if (knots == 2) begin
            dx = kx[1] - kx[0];
            dy = ky[1] - ky[0];
            if (dx == 0) dx = EPS_STEP;
            if (dy == 0) dy = EPS_STEP;
            vx = sat32(kx[0] - dx);
            vy = sat32(ky[0] - dy);
          end
        end
      end
      crce_pkg::ACT_EVAL: begin
        r.empty_error = (knots == 0);
        if (knots == 0) r.curve_value = '0;
        else if (knots == 1) r.curve_value = ky[0][31:0];
        else r.curve_value = 32'(hermite_value(c.curve_param));
        expected_values.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: a beat is accepted when start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_curve(cmd_i);
      end
      if ((!start || !busy) && pending_cmds.size() > 0 && !hold_off &&
          $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        cmd_i <= pending_cmds.pop_front();
      end else if (!start || !busy) begin
        start <= 1'b0;
        cmd_i.action <= ACT_NONE;
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    crce_pkg::rsp_t want;
    if (rst_ni) begin
      if (result_valid_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (result_valid_o) begin
        if (expected_values.size() == 0) begin
          report_mismatch("unexpected result beat", result_o.curve_value, 0);
        end else begin
          want = expected_values.pop_front();
          if (result_o.curve_value !== want.curve_value)
            report_mismatch("curve_value", result_o.curve_value, want.curve_value);
          if (result_o.empty_error !== want.empty_error)
            report_mismatch("empty_error", result_o.empty_error, want.empty_error);
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic crce_pkg::cmd_t mk(logic [1:0] a, logic signed [31:0] x,
                                        logic signed [31:0] y, logic [16:0] t);
    crce_pkg::cmd_t c;
    c.action = a;
    c.point_x = x;
    c.point_y = y;
    c.curve_param = t;
    return c;
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return $urandom;
      default: return $urandom_range(65536);
    endcase
  endfunction

  // Builds one curve with random length and ordering, then evaluates it.
  task automatic queue_curve(output int n_items);
    int          npts;
    int          nevals;
    logic signed [31:0] x;
    logic signed [31:0] step;
    npts = ($urandom_range(9) == 0) ? $urandom_range(70, 40) : $urandom_range(8, 1);
    nevals = $urandom_range(6, 1);
    x = $signed($urandom_range(200000)) - 100000;
    step = 0;
    n_items = 0;
    for (int i = 0; i < npts; i++) begin
      if ($urandom_range(19) == 0) x = rand_coord();
      else if ($urandom_range(9) == 0) step = -$signed($urandom_range(5000));
      else if ($urandom_range(9) == 0) step = 0;
      else step = $urandom_range(300000, 1);
      pending_cmds.push_back(mk(i == 0 && $urandom_range(9) != 0 ? crce_pkg::ACT_NEW
                                                                 : crce_pkg::ACT_APPEND,
                                x, ($urandom_range(7) == 0) ? rand_coord()
                                  : $signed($urandom_range(400000)) - 200000,
                                $urandom));
      x = x + step;
      n_items++;
    end
    for (int i = 0; i < nevals; i++) begin
      pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, $urandom, $urandom, rand_param()));
      n_items++;
    end
    if ($urandom_range(15) == 0) begin
      pending_cmds.push_back(mk(ACT_NONE, $urandom, $urandom, $urandom));
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_values.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int n;
    knots = 0;
    vx = 0;
    vy = 0;
    cmd_i.action = ACT_NONE;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty curve, append to empty, single point, extremes.
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd0));
    pending_cmds.push_back(mk(ACT_NONE, -1, -1, 17'h1FFFF));
    pending_cmds.push_back(mk(crce_pkg::ACT_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd65536));
    pending_cmds.push_back(mk(crce_pkg::ACT_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'h1FFFF));
    pending_cmds.push_back(mk(crce_pkg::ACT_NEW, 32'sh8000_0000, 32'sh8000_0000, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, -1, -1, 17'd0));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd32768));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd65536));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'h1FFFF));
    pending_cmds.push_back(mk(crce_pkg::ACT_NEW, 0, 0, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_APPEND, 32'h10000, 32'h20000, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_APPEND, 32'h30000, -32'sh10000, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_APPEND, 32'h20000, 32'h50000, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd16384));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd49152));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd65536));
    sent = 19;

    // Fill to capacity and past it.
    pending_cmds.push_back(mk(crce_pkg::ACT_NEW, 0, 0, 0));
    for (int i = 1; i < MAXP + 3; i++)
      pending_cmds.push_back(mk(crce_pkg::ACT_APPEND, i * 32'h8000, $urandom, 0));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd65535));
    pending_cmds.push_back(mk(crce_pkg::ACT_EVAL, 0, 0, 17'd65536));
    sent += MAXP + 5;
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 77 : 0;
      for (int k = 0; k < 700 && sent < 1850 * (phase + 1) / 3;) begin
        queue_curve(n);
        sent += n;
        k += n;
        while (pending_cmds.size() > 8) @(posedge clk_i);
      end
      if (phase == 0) begin
        // Let every expected result come back before sending more.
        hold_off = 1'b1;
        while (start || expected_values.size() > 0) @(posedge clk_i);
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
    end
    drain();
    stim_done = 1'b1;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (stim_done) begin
        if (mismatches == 0) begin
          $display("catmull_rom_curve_eval test passed");
        end else begin
          $display("catmull_rom_curve_eval test failed");
        end
        $finish;
      end else if (quiet_cycles >= WDOG_MAX) begin
        $display("watchdog expired with %0d results outstanding", expected_values.size());
        $display("catmull_rom_curve_eval test failed");
        $finish;
      end
    end
  end

endmodule
